[rtl/dhcp_lease_prefix_tracker_assert.svh]
// assertion macros used by the lease tracker table rtl
`ifndef DHCP_LEASE_PREFIX_TRACKER_ASSERT_SVH
`define DHCP_LEASE_PREFIX_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define DLPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhcp lease tracker check failed");
// next-cycle implication
`define DLPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhcp lease tracker check failed");
`else
`define DLPT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DLPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/dlpt_pkg.sv]
// shared types, codes and prefix helpers of the lease tracker
package dlpt_pkg;

   localparam int unsigned NUM_PFX = 3;

   // request kinds
   localparam logic [1:0] REQ_ACK     = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;

   // register indexes
   localparam logic [2:0] REG_PFX_A_ADDR = 3'd0;
   localparam logic [2:0] REG_PFX_A_LEN  = 3'd1;
   localparam logic [2:0] REG_PFX_B_ADDR = 3'd2;
   localparam logic [2:0] REG_PFX_B_LEN  = 3'd3;
   localparam logic [2:0] REG_PFX_C_ADDR = 3'd4;
   localparam logic [2:0] REG_PFX_C_LEN  = 3'd5;
   localparam logic [2:0] REG_LEASE_SECS = 3'd6;

   localparam logic [5:0]  LEN_RESET   = 6'd32;
   localparam logic [23:0] LEASE_RESET = 24'(24*60*60);

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] stamp;
   } req_word_type;

   typedef struct packed {
      logic [NUM_PFX-1:0][31:0] addr;
      logic [NUM_PFX-1:0][5:0]  len;
      logic [23:0]              lease_secs;
   } cfg_type;

   // lengths above 32 act as 32
   function automatic logic [5:0] clamp_len(logic [5:0] len);
      return (len > 6'd32) ? 6'd32 : len;
   endfunction

   function automatic logic [31:0] prefix_mask(logic [5:0] len);
      logic [5:0] l;
      l = clamp_len(len);
      if (len == 6'd0) begin
         return '0;
      end
      return 32'hFFFF_FFFF << (6'd32 - l);
   endfunction

   // (2^(32-len)-2)/2 truncated toward zero
   function automatic logic [31:0] half_hosts(logic [5:0] len);
      logic [5:0] l;
      l = clamp_len(len);
      if (l >= 6'd31) begin
         return '0;
      end
      return (32'd1 << (6'd31 - l)) - 32'd1;
   endfunction

endpackage

[rtl/dlpt_table.sv]
// lease table: slot memories, valid bits and the slot-sweep sequencer
`include "dhcp_lease_prefix_tracker_assert.svh"

module dlpt_table
   import dlpt_pkg::*;
#(
   parameter int unsigned LEASE_SLOTS = 64,
   parameter int unsigned CNT_W       = 7
)
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start_i,
   input  req_word_type                      req_i,
   input  cfg_type                           cfg_i,
   output logic                              ready_o,
   output logic                              res_valid_o,
   input  logic                              res_take_i,
   output logic [NUM_PFX-1:0][CNT_W-1:0]     cnt_o,
   output logic [CNT_W-1:0]                  total_o,
   output logic                              full_o
);

   localparam int unsigned IDX_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEASE_SLOTS - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_LOOK  = 5'b00010,
      S_UPD   = 5'b00100,
      S_SWEEP = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   logic [31:0] addr_mem [LEASE_SLOTS];
   logic [32:0] exp_mem  [LEASE_SLOTS];
   logic [31:0] rd_addr_ff;
   logic [32:0] rd_exp_ff;

   state_type                    state_ff, state_in;
   req_word_type                 req_ff, req_in;
   logic [32:0]                  exp_ff, exp_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic                         issue_ff, issue_in;
   logic                         p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]             p_idx_ff, p_idx_in;
   logic                         p_last_ff, p_last_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             slot_ff, slot_in;
   logic                         free_ff, free_in;
   logic [IDX_W-1:0]             free_slot_ff, free_slot_in;
   logic                         full_ff, full_in;
   logic [LEASE_SLOTS-1:0]       valid_ff, valid_in;
   logic [NUM_PFX-1:0][CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]             total_ff, total_in;

   logic                         mem_wr_addr;
   logic                         mem_wr_exp;
   logic [IDX_W-1:0]             mem_wr_slot;
   logic                         cur_valid;
   logic                         stale;
   logic [NUM_PFX-1:0]           hit;

   // slot memories, one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (mem_wr_addr) begin
         addr_mem[mem_wr_slot] <= req_ff.addr;
      end
      rd_addr_ff <= addr_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (mem_wr_exp) begin
         exp_mem[mem_wr_slot] <= exp_ff;
      end
      rd_exp_ff <= exp_mem[idx_ff];
   end

   // prefix match of the slot just read
   always_comb begin
      for (int k = 0; k < NUM_PFX; k++) begin
         hit[k] = ((rd_addr_ff ^ cfg_i.addr[k]) & prefix_mask(cfg_i.len[k])) == 32'd0;
      end
   end

   assign cur_valid = valid_ff[p_idx_ff];
   assign stale     = (req_ff.kind == REQ_ACK) && (rd_exp_ff < {1'b0, req_ff.stamp});

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      exp_in       = exp_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      full_in      = full_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      mem_wr_addr  = 1'b0;
      mem_wr_exp   = 1'b0;
      mem_wr_slot  = found_ff ? slot_ff : free_slot_ff;

      // read-issue pipeline
      p_vld_in  = issue_ff;
      p_idx_in  = idx_ff;
      p_last_in = (idx_ff == LAST_IDX);
      if (issue_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               req_in   = req_i;
               exp_in   = {1'b0, req_i.stamp} + {9'd0, cfg_i.lease_secs};
               idx_in   = '0;
               issue_in = 1'b1;
               found_in = 1'b0;
               free_in  = 1'b0;
               full_in  = 1'b0;
               cnt_in   = '0;
               total_in = '0;
               if ((req_i.kind == REQ_ACK) || (req_i.kind == REQ_RELEASE)) begin
                  state_in = S_LOOK;
               end else begin
                  state_in = S_SWEEP;
               end
            end
         end
         S_LOOK: begin
            if (p_vld_ff) begin
               if (cur_valid && (rd_addr_ff == req_ff.addr) && !found_ff) begin
                  found_in = 1'b1;
                  slot_in  = p_idx_ff;
               end
               if (!cur_valid && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = p_idx_ff;
               end
               if (p_last_ff) begin
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            if (req_ff.kind == REQ_ACK) begin
               if (found_ff) begin
                  mem_wr_exp = 1'b1;
               end else if (free_ff) begin
                  mem_wr_exp             = 1'b1;
                  mem_wr_addr            = 1'b1;
                  valid_in[free_slot_ff] = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end else if (found_ff) begin
               valid_in[slot_ff] = 1'b0;
            end
            idx_in   = '0;
            issue_in = 1'b1;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            if (p_vld_ff) begin
               if (cur_valid && stale) begin
                  valid_in[p_idx_ff] = 1'b0;
               end
               if (cur_valid && !stale) begin
                  total_in = total_ff + CNT_W'(1);
                  for (int k = 0; k < NUM_PFX; k++) begin
                     cnt_in[k] = cnt_ff[k] + CNT_W'(hit[k]);
                  end
               end
               if (p_last_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (res_take_i) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         issue_ff <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         issue_ff <= issue_in;
         p_vld_ff <= p_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      exp_ff       <= exp_in;
      idx_ff       <= idx_in;
      p_idx_ff     <= p_idx_in;
      p_last_ff    <= p_last_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      free_ff      <= free_in;
      free_slot_ff <= free_slot_in;
      full_ff      <= full_in;
      cnt_ff       <= cnt_in;
      total_ff     <= total_in;
   end

   assign ready_o     = (state_ff == S_IDLE);
   assign res_valid_o = (state_ff == S_DONE);
   assign cnt_o       = cnt_ff;
   assign total_o     = total_ff;
   assign full_o      = full_ff;

   `DLPT_ASSERT_IMPL(a_total_is_valid_count, clock, reset, state_ff == S_DONE, 32'(total_ff) == $countones(valid_ff))
   `DLPT_ASSERT_IMPL(a_prefix_within_total, clock, reset, state_ff == S_DONE, (cnt_ff[0] <= total_ff) && (cnt_ff[1] <= total_ff) && (cnt_ff[2] <= total_ff))
   `DLPT_ASSERT_IMPL(a_full_only_on_new_ack, clock, reset, (state_ff == S_DONE) && full_ff, (req_ff.kind == REQ_ACK) && !found_ff && !free_ff)
   `DLPT_ASSERT_NEXT(a_start_leaves_idle, clock, reset, (state_ff == S_IDLE) && start_i, (state_ff == S_LOOK) || (state_ff == S_SWEEP))

endmodule

[rtl/dhcp_lease_prefix_tracker.sv]
// top level: register port, request intake, lease table and result register
// an acknowledge or release walks the table twice (lookup, then sweep), other request
//    kinds walk it once (sweep only); a new word is taken only after the table has
//    handed its last result on; the lease table is walked one slot per cycle through
//    the single read port of each slot memory; the sweep counts, and prunes on acknowledge
// reset: synchronous, clears valid bits, sequencer and result valid; registers to defaults
// slot memories are not cleared, an entry is used only while its valid bit is set
module dhcp_lease_prefix_tracker
   import dlpt_pkg::*;
#(
   parameter int unsigned LEASE_SLOTS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   // request word
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_address,
   input  logic [31:0] req_timestamp,
   // result word
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_count_a,
   output logic [6:0]  rsp_count_b,
   output logic [6:0]  rsp_count_c,
   output logic        rsp_over_half_a,
   output logic        rsp_over_half_b,
   output logic        rsp_over_half_c,
   output logic [6:0]  rsp_total_leases,
   output logic        rsp_table_full,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // counters must hold the slot count itself; reported values wrap at 128
   localparam int unsigned CNT_W =
      ($clog2(LEASE_SLOTS + 1) > 7) ? $clog2(LEASE_SLOTS + 1) : 7;

   cfg_type                       cfg_ff, cfg_in;
   logic [2:0]                    reg_idx;
   logic                          reg_wr;

   req_word_type                  req_word;
   logic                          start;
   logic                          eng_ready;
   logic                          eng_res_valid;
   logic                          res_take;
   logic [NUM_PFX-1:0][CNT_W-1:0] eng_cnt;
   logic [CNT_W-1:0]              eng_total;
   logic                          eng_full;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [NUM_PFX-1:0][6:0]       rsp_cnt_ff, rsp_cnt_in;
   logic [NUM_PFX-1:0]            rsp_over_ff, rsp_over_in;
   logic [6:0]                    rsp_total_ff, rsp_total_in;
   logic                          rsp_full_ff, rsp_full_in;

   // register port: no wait states, word index from paddr[4:2]
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign reg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (reg_wr) begin
         case (reg_idx)
            REG_PFX_A_ADDR: cfg_in.addr[0]    = csr_pwdata;
            REG_PFX_A_LEN:  cfg_in.len[0]     = csr_pwdata[5:0];
            REG_PFX_B_ADDR: cfg_in.addr[1]    = csr_pwdata;
            REG_PFX_B_LEN:  cfg_in.len[1]     = csr_pwdata[5:0];
            REG_PFX_C_ADDR: cfg_in.addr[2]    = csr_pwdata;
            REG_PFX_C_LEN:  cfg_in.len[2]     = csr_pwdata[5:0];
            REG_LEASE_SECS: cfg_in.lease_secs = csr_pwdata[23:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PFX_A_ADDR: csr_prdata = cfg_ff.addr[0];
         REG_PFX_A_LEN:  csr_prdata = {26'd0, cfg_ff.len[0]};
         REG_PFX_B_ADDR: csr_prdata = cfg_ff.addr[1];
         REG_PFX_B_LEN:  csr_prdata = {26'd0, cfg_ff.len[1]};
         REG_PFX_C_ADDR: csr_prdata = cfg_ff.addr[2];
         REG_PFX_C_LEN:  csr_prdata = {26'd0, cfg_ff.len[2]};
         REG_LEASE_SECS: csr_prdata = {8'd0, cfg_ff.lease_secs};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_PFX; k++) begin
            cfg_ff.addr[k] <= 32'd0;
            cfg_ff.len[k]  <= LEN_RESET;
         end
         cfg_ff.lease_secs <= LEASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request intake: the table takes a word only while its sequencer is idle
   assign req_word.kind  = req_type;
   assign req_word.addr  = req_address;
   assign req_word.stamp = req_timestamp;
   assign req_ready      = eng_ready;
   assign start          = req_valid && req_ready;

   dlpt_table #(
      .LEASE_SLOTS (LEASE_SLOTS),
      .CNT_W       (CNT_W)
   ) u_table (
      .clock       (clock),
      .reset       (reset),
      .start_i     (start),
      .req_i       (req_word),
      .cfg_i       (cfg_ff),
      .ready_o     (eng_ready),
      .res_valid_o (eng_res_valid),
      .res_take_i  (res_take),
      .cnt_o       (eng_cnt),
      .total_o     (eng_total),
      .full_o      (eng_full)
   );

   // result register: loads when empty or drained in the same cycle,
   // so the table can start the next word while this one waits
   assign res_take     = eng_res_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_total_in = rsp_total_ff;
      rsp_full_in  = rsp_full_ff;
      if (res_take) begin
         for (int k = 0; k < NUM_PFX; k++) begin
            rsp_cnt_in[k]  = eng_cnt[k][6:0];
            // flag when the count passes half of the usable hosts
            rsp_over_in[k] = 32'(eng_cnt[k]) > half_hosts(cfg_ff.len[k]);
         end
         rsp_total_in = eng_total[6:0];
         rsp_full_in  = eng_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_over_ff  <= rsp_over_in;
      rsp_total_ff <= rsp_total_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_count_a      = rsp_cnt_ff[0];
   assign rsp_count_b      = rsp_cnt_ff[1];
   assign rsp_count_c      = rsp_cnt_ff[2];
   assign rsp_over_half_a  = rsp_over_ff[0];
   assign rsp_over_half_b  = rsp_over_ff[1];
   assign rsp_over_half_c  = rsp_over_ff[2];
   assign rsp_total_leases = rsp_total_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

[tb/tb_dhcp_lease_prefix_tracker.sv]
// self-checking testbench of the dhcp lease tracker: directed table, then random phases
module tb_dhcp_lease_prefix_tracker;
   import dlpt_pkg::*;

   localparam int unsigned SLOTS = 64;
   // one acknowledge walks the table twice, plus margin
   localparam int unsigned WALK_CYCLES = 2*SLOTS + 16;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_WORDS = 200;
   localparam longint unsigned RUN_LIMIT = 64'd12_000_000;

   // request kinds the package leaves unnamed
   localparam logic [1:0] REQ_OTHER = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   typedef struct packed {
      logic [6:0] count_a, count_b, count_c;
      logic       half_a, half_b, half_c;
      logic [6:0] total;
      logic       full;
   } tally_type;

   // one directed row; tally is used only when pinned is set
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] addr;
      logic [31:0] stamp;
      logic        pinned;
      tally_type   tally;
   } stim_row_type;

   localparam logic PINNED = 1'b1;
   localparam logic PREDICTED = 1'b0;
   localparam tally_type NO_TALLY = '0;
   localparam tally_type ONE_HOST = {7'd0, 7'd0, 7'd0, 3'b000, 7'd1, 1'b0};

   // rows before DIR_RECONFIG_ROW run on reset registers, the rest on the directed profile
   localparam int DIR_RECONFIG_ROW = 7;
   localparam stim_row_type DIRECTED [17] = '{
      // empty table, other kind and the spare code report zeros
      {REQ_OTHER,   32'h0000_0000, 32'h0000_0000, PINNED, NO_TALLY},
      {REQ_SPARE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, PINNED, NO_TALLY},
      // address 0 hits every 0/32 prefix, threshold of a host prefix is 0
      {REQ_ACK,     32'h0000_0000, 32'h0000_0000, PINNED,
         {7'd1, 7'd1, 7'd1, 3'b111, 7'd1, 1'b0}},
      // latest timestamp prunes the first lease, expiry goes past 32 bits
      {REQ_ACK,     32'hFFFF_FFFF, 32'hFFFF_FFFF, PINNED, ONE_HOST},
      // refresh with an earlier stamp
      {REQ_ACK,     32'hFFFF_FFFF, 32'h0000_0000, PINNED, ONE_HOST},
      // release of an unknown address changes nothing
      {REQ_RELEASE, 32'h1234_5678, 32'h0000_0005, PINNED, ONE_HOST},
      {REQ_RELEASE, 32'hFFFF_FFFF, 32'h0000_0006, PINNED, NO_TALLY},
      // zero lease time: leases expire at their own stamp
      {REQ_ACK,     32'hC0A8_0100, 32'd1000, PREDICTED, NO_TALLY},
      {REQ_ACK,     32'hC0A8_0101, 32'd1000, PREDICTED, NO_TALLY},
      {REQ_ACK,     32'hC0A8_0105, 32'd1000, PREDICTED, NO_TALLY},
      {REQ_ACK,     32'h0A00_0001, 32'd1001, PREDICTED, NO_TALLY},
      {REQ_ACK,     32'hC0A8_0100, 32'd1001, PREDICTED, NO_TALLY},
      // release does not prune the stale lease
      {REQ_RELEASE, 32'hC0A8_0100, 32'd1002, PREDICTED, NO_TALLY},
      // refresh of a lease whose expiry has passed
      {REQ_ACK,     32'h0A00_0001, 32'd2000, PREDICTED, NO_TALLY},
      {REQ_OTHER,   32'hC0A8_0105, 32'd2000, PREDICTED, NO_TALLY},
      {REQ_SPARE,   32'h0A00_0001, 32'd2000, PREDICTED, NO_TALLY},
      {REQ_RELEASE, 32'h0A00_0001, 32'd2001, PREDICTED, NO_TALLY}
   };

   // block ports, all inputs known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = '0;
   logic [31:0] req_address = '0;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic [6:0]  rsp_count_a, rsp_count_b, rsp_count_c, rsp_total_leases;
   logic        rsp_over_half_a, rsp_over_half_b, rsp_over_half_c, rsp_table_full;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // shadow registers and lease table of the predictor
   logic [31:0] pfx_base [3];
   logic [5:0]  pfx_bits [3];
   logic [23:0] lease_secs;
   logic [31:0] slot_addr [SLOTS];
   logic [32:0] slot_expiry [SLOTS];
   logic        slot_live [SLOTS];

   tally_type pending_tallies [$];
   // a directed row may pin its expected tally; driven along with the word
   logic      pin_on = 1'b0;
   tally_type pin_tally = '0;

   int errors = 0;
   int words_sent = 0;
   int words_back = 0;
   int acks_seen = 0;
   int releases_seen = 0;
   int drops_seen = 0;
   int peak_total = 0;
   int profiles_loaded = 0;

   // sender pacing and receiver stall pattern
   int gap_max = 0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_max = 0;
   int stall_left = 0;

   dhcp_lease_prefix_tracker #(
      .LEASE_SLOTS(SLOTS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_address      (req_address),
      .req_timestamp    (req_timestamp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_count_a      (rsp_count_a),
      .rsp_count_b      (rsp_count_b),
      .rsp_count_c      (rsp_count_c),
      .rsp_over_half_a  (rsp_over_half_a),
      .rsp_over_half_b  (rsp_over_half_b),
      .rsp_over_half_c  (rsp_over_half_c),
      .rsp_total_leases (rsp_total_leases),
      .rsp_table_full   (rsp_table_full),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // apply one event to the shadow table and tally the leases per prefix
   function automatic tally_type apply_dhcp_event(logic [1:0] kind, logic [31:0] addr,
                                                  logic [31:0] stamp);
      tally_type   t;
      int          hit;
      int          hits [3];
      int          live_cnt;
      logic [32:0] due;
      logic [31:0] m;
      int unsigned l;
      longint      limit;
      t = '0;
      hit = -1;
      hits = '{0, 0, 0};
      live_cnt = 0;
      // 33-bit expiry, never wraps
      due = {1'b0, stamp} + {9'd0, lease_secs};
      for (int i = 0; i < SLOTS; i++) begin
         if (hit < 0 && slot_live[i] && slot_addr[i] == addr) begin
            hit = i;
         end
      end
      if (kind == REQ_ACK) begin
         if (hit < 0) begin
            // new address takes the lowest free slot
            for (int i = 0; i < SLOTS; i++) begin
               if (hit < 0 && !slot_live[i]) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               slot_live[hit] = 1'b1;
               slot_addr[hit] = addr;
            end else begin
               t.full = 1'b1;
            end
         end
         if (hit >= 0) begin
            slot_expiry[hit] = due;
         end
         // prune strictly expired leases
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i] && slot_expiry[i] < {1'b0, stamp}) begin
               slot_live[i] = 1'b0;
            end
         end
      end else if (kind == REQ_RELEASE && hit >= 0) begin
         slot_live[hit] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i]) begin
            live_cnt++;
            for (int k = 0; k < 3; k++) begin
               l = (pfx_bits[k] > 6'd32) ? 32 : pfx_bits[k];
               m = (l == 0) ? 32'd0 : 32'hFFFF_FFFF << (32 - l);
               if ((slot_addr[i] & m) == (pfx_base[k] & m)) begin
                  hits[k]++;
               end
            end
         end
      end
      t.count_a = 7'(hits[0]);
      t.count_b = 7'(hits[1]);
      t.count_c = 7'(hits[2]);
      t.total = 7'(live_cnt);
      for (int k = 0; k < 3; k++) begin
         l = (pfx_bits[k] > 6'd32) ? 32 : pfx_bits[k];
         // half of the usable hosts, zero for /31 and /32
         limit = (l >= 31) ? 0 : (longint'(1) << (31 - l)) - 1;
         if (k == 0) t.half_a = (hits[k] > limit);
         if (k == 1) t.half_b = (hits[k] > limit);
         if (k == 2) t.half_c = (hits[k] > limit);
      end
      return t;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   // receiver stall pattern: runs of low ready of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (stall_max != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(1, stall_max);
         end
      end
   end

   // predict on every accepted request word, check every accepted result word
   always @(posedge clock) begin
      tally_type want;
      tally_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = apply_dhcp_event(req_type, req_address, req_timestamp);
            if (pin_on) begin
               want = pin_tally;
            end
            pending_tallies.push_back(want);
            if (req_type == REQ_ACK) acks_seen++;
            if (req_type == REQ_RELEASE) releases_seen++;
            if (want.full) drops_seen++;
            if (want.total > peak_total) peak_total = want.total;
         end
         if (rsp_valid && rsp_ready) begin
            words_back++;
            got = {rsp_count_a, rsp_count_b, rsp_count_c, rsp_over_half_a,
                   rsp_over_half_b, rsp_over_half_c, rsp_total_leases, rsp_table_full};
            if (pending_tallies.size() == 0) begin
               $display("%0t result word with no prediction waiting", $time);
               errors++;
            end else begin
               want = pending_tallies.pop_front();
               check_field("count_a", want.count_a, got.count_a);
               check_field("count_b", want.count_b, got.count_b);
               check_field("count_c", want.count_c, got.count_c);
               check_field("over_half_a", want.half_a, got.half_a);
               check_field("over_half_b", want.half_b, got.half_b);
               check_field("over_half_c", want.half_c, got.half_c);
               check_field("total_leases", want.total, got.total);
               check_field("table_full", want.full, got.full);
            end
         end
      end
   end

   // one register access, setup then access phase, then back to idle
   task automatic csr_access(logic [2:0] idx, logic wr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] shadow_reg(logic [2:0] idx);
      case (idx)
         REG_PFX_A_ADDR: return pfx_base[0];
         REG_PFX_A_LEN:  return {26'd0, pfx_bits[0]};
         REG_PFX_B_ADDR: return pfx_base[1];
         REG_PFX_B_LEN:  return {26'd0, pfx_bits[1]};
         REG_PFX_C_ADDR: return pfx_base[2];
         REG_PFX_C_LEN:  return {26'd0, pfx_bits[2]};
         REG_LEASE_SECS: return {8'd0, lease_secs};
         default:        return '0;
      endcase
   endfunction

   task automatic csr_verify(logic [2:0] idx);
      logic [31:0] rd;
      csr_access(idx, 1'b0, '0, rd);
      if (rd !== shadow_reg(idx)) begin
         $display("%0t register %0d readback: expected %h, got %h", $time, idx,
                  shadow_reg(idx), rd);
         errors++;
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      logic [31:0] unused;
      csr_access(idx, 1'b1, value, unused);
      case (idx)
         REG_PFX_A_ADDR: pfx_base[0] = value;
         REG_PFX_A_LEN:  pfx_bits[0] = value[5:0];
         REG_PFX_B_ADDR: pfx_base[1] = value;
         REG_PFX_B_LEN:  pfx_bits[1] = value[5:0];
         REG_PFX_C_ADDR: pfx_base[2] = value;
         REG_PFX_C_LEN:  pfx_bits[2] = value[5:0];
         REG_LEASE_SECS: lease_secs = value[23:0];
         default: ;
      endcase
      csr_verify(idx);
   endtask

   // write every register, block must be idle
   task automatic load_profile(logic [31:0] a_addr, logic [5:0] a_len,
                               logic [31:0] b_addr, logic [5:0] b_len,
                               logic [31:0] c_addr, logic [5:0] c_len,
                               logic [23:0] secs);
      csr_write(REG_PFX_A_ADDR, a_addr);
      csr_write(REG_PFX_A_LEN, {26'd0, a_len});
      csr_write(REG_PFX_B_ADDR, b_addr);
      csr_write(REG_PFX_B_LEN, {26'd0, b_len});
      csr_write(REG_PFX_C_ADDR, c_addr);
      csr_write(REG_PFX_C_LEN, {26'd0, c_len});
      csr_write(REG_LEASE_SECS, {8'd0, secs});
      profiles_loaded++;
   endtask

   // drive one word and hold it until accepted; bursts end in a random gap
   task automatic send_word(logic [1:0] kind, logic [31:0] addr, logic [31:0] stamp,
                            logic pinned, tally_type pinned_tally);
      int gap;
      req_valid <= 1'b1;
      req_type <= kind;
      req_address <= addr;
      req_timestamp <= stamp;
      pin_on <= pinned;
      pin_tally <= pinned_tally;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop sending until every predicted word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (words_back != words_sent) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] pool_base;
      logic [31:0] cur_time;
      logic [31:0] pa [3];
      logic [5:0]  pl [3];
      logic [23:0] secs;
      int unsigned adv_max;
      int          phase_start;
      int          pick;
      int          run;
      logic [1:0]  kind;

      // reset values of the shadow registers and table
      for (int k = 0; k < 3; k++) begin
         pfx_base[k] = '0;
         pfx_bits[k] = LEN_RESET;
      end
      lease_secs = LEASE_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         slot_addr[i] = '0;
         slot_expiry[i] = '0;
         slot_live[i] = 1'b0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values read back
      for (int r = REG_PFX_A_ADDR; r <= REG_LEASE_SECS; r++) begin
         csr_verify(3'(r));
      end

      // directed table, light idling on the sender only
      gap_max = 4;
      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (i == DIR_RECONFIG_ROW) begin
            // length 0 matches all, /31 host pair, length 40 acts as /32, zero lease time
            wait_for_results();
            load_profile(32'hC0A8_0100, 6'd0, 32'hC0A8_0100, 6'd31,
                         32'hC0A8_0105, 6'd40, 24'd0);
         end
         send_word(DIRECTED[i].kind, DIRECTED[i].addr, DIRECTED[i].stamp,
                   DIRECTED[i].pinned, DIRECTED[i].tally);
      end
      wait_for_results();

      // random phases, each with its own register profile and pacing
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pool_base = $urandom;
         case (p)
            0: begin
               // longest lease, least pruning: table fills; extreme prefix bases
               pa = '{32'h0000_0000, 32'hFFFF_FFFF, pool_base & ~32'h7F};
               pl = '{6'd1, 6'd32, 6'd25};
               secs = 24'hFF_FFFF;
            end
            1: begin
               pa = '{pool_base, pool_base ^ 32'd1, pool_base & ~32'h3F};
               pl = '{6'd0, 6'd31, 6'd63};
               secs = 24'd0;
            end
            2: begin
               for (int k = 0; k < 3; k++) begin
                  pa[k] = $urandom;
                  pl[k] = $urandom_range(0, 63);
               end
               secs = 24'd1;
            end
            default: begin
               for (int k = 0; k < 3; k++) begin
                  pa[k] = ($urandom_range(0, 3) == 0) ? $urandom
                                                      : pool_base ^ $urandom_range(0, 127);
                  pl[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(24, 33);
               end
               case ($urandom_range(0, 3))
                  0: secs = $urandom_range(1, 300);
                  1: secs = LEASE_RESET;
                  2: secs = $urandom_range(1, 24'hFF_FFFF);
                  default: secs = $urandom_range(2000, 20000);
               endcase
            end
         endcase
         load_profile(pa[0], pl[0], pa[1], pl[1], pa[2], pl[2], secs);

         // pacing: none, short or long gaps; stall patterns cycle independently
         gap_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 24 : 180;
         case (p % 4)
            0: begin stall_pct <= 0;  stall_max <= 0;   end
            1: begin stall_pct <= 10; stall_max <= 6;   end
            2: begin stall_pct <= 2;  stall_max <= 160; end
            default: begin stall_pct <= 30; stall_max <= 3; end
         endcase

         adv_max = lease_secs / 4 + 3;
         cur_time = (p == 1) ? 32'hFFFF_FFFF - 32'd4000 : $urandom;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               // fill run of distinct addresses at one stamp, may overflow the table
               run = $urandom_range(60, 72);
               for (int j = 0; j < run; j++) begin
                  send_word(REQ_ACK, pool_base ^ 32'(j), cur_time, PREDICTED, NO_TALLY);
               end
            end else if (pick < 6) begin
               // release sweep across the pool
               run = $urandom_range(8, 24);
               for (int j = 0; j < run; j++) begin
                  send_word(REQ_RELEASE, pool_base ^ $urandom_range(0, 95), cur_time,
                            PREDICTED, NO_TALLY);
               end
            end else if (pick < 7) begin
               wait_for_results();
            end else begin
               // move the clock: mostly forward, sometimes still or backward
               pick = $urandom_range(0, 99);
               if (pick < 70) begin
                  cur_time = cur_time + $urandom_range(0, adv_max);
               end else if (pick >= 90) begin
                  cur_time = cur_time - $urandom_range(0, adv_max);
               end
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  send_word(REQ_ACK, pool_base ^ $urandom_range(0, 95), cur_time,
                            PREDICTED, NO_TALLY);
               end else if (pick < 75) begin
                  send_word(REQ_RELEASE, pool_base ^ $urandom_range(0, 95), cur_time,
                            PREDICTED, NO_TALLY);
               end else if (pick < 83) begin
                  kind = ($urandom_range(0, 1) == 0) ? REQ_OTHER : REQ_SPARE;
                  send_word(kind, pool_base ^ $urandom_range(0, 95), cur_time,
                            PREDICTED, NO_TALLY);
               end else begin
                  // noise: any kind, any address, any stamp
                  send_word(2'($urandom_range(0, 3)), $urandom, $urandom,
                            PREDICTED, NO_TALLY);
               end
            end
         end
         wait_for_results();
      end

      // let the block settle; any stray word is flagged by the checker
      stall_pct <= 0;
      stall_max <= 0;
      repeat (WALK_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d acknowledges, %0d releases, %0d dropped on a full table",
               words_sent, acks_seen, releases_seen, drops_seen);
      $display("peak occupancy %0d of %0d slots across %0d register profiles",
               peak_total, SLOTS, profiles_loaded);
      if (errors == 0) begin
         $display("tb_dhcp_lease_prefix_tracker OK");
      end else begin
         $display("tb_dhcp_lease_prefix_tracker NOT OK");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(RUN_LIMIT);
      $display("timeout with %0d words still outstanding", words_sent - words_back);
      $display("tb_dhcp_lease_prefix_tracker NOT OK");
      $finish;
   end

endmodule
